FILE: sv/commented_hex_text_to_bytes_assert.svh
// assertion macros for the hex text parser checker
// relies on clk and rst being visible where a macro is used
`ifndef COMMENTED_HEX_TEXT_TO_BYTES_ASSERT_SVH
`define COMMENTED_HEX_TEXT_TO_BYTES_ASSERT_SVH

// same-cycle implication, disabled during reset
`define HEXTB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled during reset
`define HEXTB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: sv/hextb_pkg.sv
// shared types, character codes and decode functions for the hex text parser
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package hextb_pkg;

  typedef enum logic [2:0] {
    MODE_SEEK    = 3'd0,
    MODE_SLASH   = 3'd1,
    MODE_COMMENT = 3'd2,
    MODE_LOWER   = 3'd3,
    MODE_ERROR   = 3'd4
  } parse_mode_t;

  localparam logic [1:0] STATUS_RUN   = 2'd0;
  localparam logic [1:0] STATUS_OK    = 2'd1;
  localparam logic [1:0] STATUS_ERROR = 2'd2;

  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
  localparam logic [7:0] CHAR_TAB     = 8'h09;
  localparam logic [7:0] CHAR_CR      = 8'h0D;
  localparam logic [7:0] CHAR_SPACE   = 8'h20;
  localparam logic [7:0] CHAR_SLASH   = 8'h2F;
  localparam logic [7:0] CHAR_SEMI    = 8'h3B;

  localparam logic [7:0] OFS_DIGIT = 8'h30;
  localparam logic [7:0] OFS_UPPER = 8'h37;
  localparam logic [7:0] OFS_LOWER = 8'h57;

  typedef struct packed {
    logic [7:0] char_code;
    logic       last_char;
  } char_item_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
  endfunction

  // bit 4 set means not a hex digit
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [7:0] d;
    d = 8'h00;
    if ((c >= 8'h30) && (c <= 8'h39)) begin
      d = c - OFS_DIGIT;
      return {1'b0, d[3:0]};
    end else if ((c >= 8'h41) && (c <= 8'h46)) begin
      d = c - OFS_UPPER;
      return {1'b0, d[3:0]};
    end else if ((c >= 8'h61) && (c <= 8'h66)) begin
      d = c - OFS_LOWER;
      return {1'b0, d[3:0]};
    end
    return 5'h10;
  endfunction

endpackage

`default_nettype wire

FILE: sv/hextb_in_reg.sv
// input register for the hex text parser: holds one character request
// depends on hextb_pkg
`timescale 1ns / 1ps
`default_nettype none

module hextb_in_reg
  import hextb_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       char_valid,
  output      logic       char_stall,
  input  wire char_item_t char_in,
  output      logic       item_valid,
  output      char_item_t item,
  input  wire logic       item_take
);

  logic load;

  assign load       = char_valid && !char_stall;
  assign char_stall = item_valid && !item_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (load) begin
      item_valid <= 1'b1;
    end else if (item_take) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item <= char_in;
    end
  end

endmodule

`default_nettype wire

FILE: sv/hextb_core.sv
// parser state and per-character step logic for the hex text parser
// depends on hextb_pkg
`timescale 1ns / 1ps
`default_nettype none

module hextb_core
  import hextb_pkg::*;
#(
  parameter int LINE_BITS   = 20,
  parameter int COLUMN_BITS = 16
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   item_valid,
  input  wire char_item_t             item,
  output      logic                   item_take,
  input  wire logic                   out_ready,
  output      logic                   res_load,
  output      logic                   res_has_byte,
  output      logic [7:0]             res_byte_value,
  output      logic [1:0]             res_status,
  output      logic [LINE_BITS-1:0]   res_error_line,
  output      logic [COLUMN_BITS-1:0] res_error_column
);

  localparam logic [LINE_BITS-1:0]   LINE_MAX = '1;
  localparam logic [COLUMN_BITS-1:0] COL_MAX  = '1;

  parse_mode_t             mode, mode_next;
  logic [3:0]              upper_digit, upper_digit_next;
  logic [LINE_BITS-1:0]    line_count, line_count_next;
  logic [COLUMN_BITS-1:0]  column_count, column_count_next;

  logic [7:0]              c;
  logic [4:0]              hv;
  logic                    is_hex;
  logic                    is_nl;
  logic [LINE_BITS-1:0]    line_inc;
  logic [COLUMN_BITS-1:0]  col_inc1, col_inc2;
  logic [LINE_BITS-1:0]    line_adv;
  logic [COLUMN_BITS-1:0]  col_adv;
  logic                    was_error;
  logic                    error;
  logic                    produce;

  assign c      = item.char_code;
  assign hv     = hex_value(c);
  assign is_hex = !hv[4];
  assign is_nl  = (c == CHAR_NEWLINE);

  // saturating counters
  assign line_inc = (line_count == LINE_MAX) ? line_count : line_count + LINE_BITS'(1);
  assign col_inc1 = (column_count == COL_MAX) ? column_count
                                              : column_count + COLUMN_BITS'(1);
  assign col_inc2 = (col_inc1 == COL_MAX) ? col_inc1 : col_inc1 + COLUMN_BITS'(1);
  assign line_adv = is_nl ? line_inc : line_count;
  assign col_adv  = is_nl ? '0 : col_inc1;

  assign was_error = !((mode == MODE_SEEK) || (mode == MODE_SLASH) ||
                       (mode == MODE_COMMENT) || (mode == MODE_LOWER));

  always_comb begin
    mode_next         = mode;
    upper_digit_next  = upper_digit;
    line_count_next   = line_count;
    column_count_next = column_count;
    error             = 1'b0;
    produce           = 1'b0;
    res_has_byte      = 1'b0;
    res_byte_value    = 8'h00;
    res_status        = STATUS_RUN;
    res_error_line    = '0;
    res_error_column  = '0;

    unique case (mode)
      MODE_SEEK: begin
        priority if (is_space(c)) begin
          line_count_next   = line_adv;
          column_count_next = col_adv;
        end else if (c == CHAR_SEMI) begin
          line_count_next   = line_adv;
          column_count_next = col_adv;
          mode_next         = MODE_COMMENT;
        end else if (c == CHAR_SLASH) begin
          mode_next = MODE_SLASH;
        end else if (is_hex) begin
          upper_digit_next  = hv[3:0];
          line_count_next   = line_adv;
          column_count_next = col_adv;
          mode_next         = MODE_LOWER;
        end else begin
          error = 1'b1;
        end
      end
      MODE_SLASH: begin
        if (c == CHAR_SLASH) begin
          column_count_next = col_inc2;
          mode_next         = MODE_COMMENT;
        end else begin
          error = 1'b1;
        end
      end
      MODE_COMMENT: begin
        line_count_next   = line_adv;
        column_count_next = col_adv;
        if (is_nl) begin
          mode_next = MODE_SEEK;
        end
      end
      MODE_LOWER: begin
        if (is_hex) begin
          res_has_byte      = 1'b1;
          res_byte_value    = {upper_digit, hv[3:0]};
          produce           = 1'b1;
          line_count_next   = line_adv;
          column_count_next = col_adv;
          mode_next         = MODE_SEEK;
        end else begin
          error = 1'b1;
        end
      end
      default: begin
      end
    endcase

    if (error) begin
      res_status       = STATUS_ERROR;
      res_error_line   = line_count;
      res_error_column = column_count;
      produce          = 1'b1;
      mode_next        = MODE_ERROR;
    end

    if (item.last_char) begin
      if (!error && !was_error) begin
        res_status = STATUS_OK;
        produce    = 1'b1;
      end
      mode_next         = MODE_SEEK;
      upper_digit_next  = 4'h0;
      line_count_next   = LINE_BITS'(1);
      column_count_next = '0;
    end
  end

  // an item with no result never waits on the output side
  assign item_take = item_valid && (!produce || out_ready);
  assign res_load  = item_take && produce;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= MODE_SEEK;
      upper_digit  <= 4'h0;
      line_count   <= LINE_BITS'(1);
      column_count <= '0;
    end else if (item_take) begin
      mode         <= mode_next;
      upper_digit  <= upper_digit_next;
      line_count   <= line_count_next;
      column_count <= column_count_next;
    end
  end

endmodule

`default_nettype wire

FILE: sv/hextb_out_reg.sv
// result register for the hex text parser
// depends on hextb_pkg for nothing but the house import
`timescale 1ns / 1ps
`default_nettype none

module hextb_out_reg
  import hextb_pkg::*;
#(
  parameter int LINE_BITS   = 20,
  parameter int COLUMN_BITS = 16
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   load,
  output      logic                   out_ready,
  input  wire logic                   in_has_byte,
  input  wire logic [7:0]             in_byte_value,
  input  wire logic [1:0]             in_status,
  input  wire logic [LINE_BITS-1:0]   in_error_line,
  input  wire logic [COLUMN_BITS-1:0] in_error_column,
  output      logic                   result_valid,
  input  wire logic                   result_stall,
  output      logic                   has_byte,
  output      logic [7:0]             byte_value,
  output      logic [1:0]             status,
  output      logic [LINE_BITS-1:0]   error_line,
  output      logic [COLUMN_BITS-1:0] error_column
);

  assign out_ready = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      has_byte     <= in_has_byte;
      byte_value   <= in_byte_value;
      status       <= in_status;
      error_line   <= in_error_line;
      error_column <= in_error_column;
    end
  end

endmodule

`default_nettype wire

FILE: sv/commented_hex_text_to_bytes.sv
// top level of the commented hex text parser
// depends on hextb_pkg, hextb_in_reg, hextb_core and hextb_out_reg
//
//   channel   direction  handshake                   payload
//   char      in         char_valid / char_stall     char_code, last_char
//   result    out        result_valid / result_stall has_byte, byte_value, status,
//                                                    error_line, error_column
//
// one character request is taken every cycle when the result side keeps up
// a character passes through the input register, then the step logic into the result register
// a character that yields no result moves on even while a result waits
// rst is synchronous; it returns the parser to line 1, column 0, seeking a token
// a stalled result holds its value; char_stall rises only behind a held result
`timescale 1ns / 1ps
`default_nettype none

module commented_hex_text_to_bytes
  import hextb_pkg::*;
#(
  parameter int LINE_BITS   = 20,
  parameter int COLUMN_BITS = 16
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   char_valid,
  output      logic                   char_stall,
  input  wire logic [7:0]             char_code,
  input  wire logic                   last_char,
  output      logic                   result_valid,
  input  wire logic                   result_stall,
  output      logic                   has_byte,
  output      logic [7:0]             byte_value,
  output      logic [1:0]             status,
  output      logic [LINE_BITS-1:0]   error_line,
  output      logic [COLUMN_BITS-1:0] error_column
);

  char_item_t             char_in;
  char_item_t             item;
  logic                   item_valid;
  logic                   item_take;
  logic                   out_ready;
  logic                   res_load;
  logic                   res_has_byte;
  logic [7:0]             res_byte_value;
  logic [1:0]             res_status;
  logic [LINE_BITS-1:0]   res_error_line;
  logic [COLUMN_BITS-1:0] res_error_column;

  assign char_in.char_code = char_code;
  assign char_in.last_char = last_char;

  // input stage: parts the upstream handshake from the step logic
  hextb_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .char_valid (char_valid),
    .char_stall (char_stall),
    .char_in    (char_in),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take)
  );

  // decode, mode update and saturating line and column counters
  hextb_core #(
    .LINE_BITS   (LINE_BITS),
    .COLUMN_BITS (COLUMN_BITS)
  ) u_core (
    .clk              (clk),
    .rst              (rst),
    .item_valid       (item_valid),
    .item             (item),
    .item_take        (item_take),
    .out_ready        (out_ready),
    .res_load         (res_load),
    .res_has_byte     (res_has_byte),
    .res_byte_value   (res_byte_value),
    .res_status       (res_status),
    .res_error_line   (res_error_line),
    .res_error_column (res_error_column)
  );

  // result stage: holds a finished result while downstream stalls
  hextb_out_reg #(
    .LINE_BITS   (LINE_BITS),
    .COLUMN_BITS (COLUMN_BITS)
  ) u_out_reg (
    .clk             (clk),
    .rst             (rst),
    .load            (res_load),
    .out_ready       (out_ready),
    .in_has_byte     (res_has_byte),
    .in_byte_value   (res_byte_value),
    .in_status       (res_status),
    .in_error_line   (res_error_line),
    .in_error_column (res_error_column),
    .result_valid    (result_valid),
    .result_stall    (result_stall),
    .has_byte        (has_byte),
    .byte_value      (byte_value),
    .status          (status),
    .error_line      (error_line),
    .error_column    (error_column)
  );

endmodule

`default_nettype wire

FILE: sv/hextb_checker.sv
// port-level checks on the hex text parser results, bound to the top level
// depends on hextb_pkg and commented_hex_text_to_bytes_assert.svh
`timescale 1ns / 1ps
`default_nettype none

`include "commented_hex_text_to_bytes_assert.svh"

module hextb_checker
  import hextb_pkg::*;
#(
  parameter int LINE_BITS   = 20,
  parameter int COLUMN_BITS = 16
) (
  input wire logic                   clk,
  input wire logic                   rst,
  input wire logic                   result_valid,
  input wire logic                   result_stall,
  input wire logic                   has_byte,
  input wire logic [7:0]             byte_value,
  input wire logic [1:0]             status,
  input wire logic [LINE_BITS-1:0]   error_line,
  input wire logic [COLUMN_BITS-1:0] error_column
);

  `HEXTB_ASSERT_NEXT(a_stall_holds, result_valid && result_stall, result_valid && $stable(byte_value) && $stable(status) && $stable(error_line), "stalled result changed")
  `HEXTB_ASSERT_NOW(a_no_byte_zero, result_valid && !has_byte, byte_value == 8'h00, "byte value without a byte")
  `HEXTB_ASSERT_NOW(a_loc_only_on_error, result_valid && (status != STATUS_ERROR), (error_line == '0) && (error_column == '0), "error location outside an error")
  `HEXTB_ASSERT_NOW(a_error_line_set, result_valid && (status == STATUS_ERROR), (error_line != '0) && !has_byte, "error result with no line or with a byte")

endmodule

bind commented_hex_text_to_bytes hextb_checker #(
  .LINE_BITS   (LINE_BITS),
  .COLUMN_BITS (COLUMN_BITS)
) u_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .has_byte     (has_byte),
  .byte_value   (byte_value),
  .status       (status),
  .error_line   (error_line),
  .error_column (error_column)
);

`default_nettype wire
